// File: rtl/json_string_unescape_utf8_defines.svh
// assertion macros for the json string decoder
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define JSU_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) else $error(msg);

`define JSU_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) else $error(msg);

`else

`define JSU_ASSERT_IMP(lbl, ant, con, msg)

`define JSU_ASSERT_NEXT(lbl, ant, con, msg)

`endif

`endif

// File: rtl/jsu_pkg.sv
package jsu_pkg;

  typedef enum logic [2:0] {
    MODE_PLAIN  = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_HEX1   = 3'd2,
    MODE_SUR_BS = 3'd3,
    MODE_SUR_U  = 3'd4,
    MODE_HEX2   = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_BYTE    = 3'd0,
    ST_OK      = 3'd1,
    ST_NOQUOTE = 3'd2,
    ST_ESCAPE  = 3'd3,
    ST_HEX     = 3'd4,
    ST_SURR    = 3'd5,
    ST_CTRL    = 3'd6
  } status_t;

  typedef struct packed {
    logic [2:0]      cnt;
    logic [3:0][7:0] bytes;
    status_t         status;
  } res_t;

  localparam logic [15:0] HIGH_SUR_MIN = 16'hD800;
  localparam logic [15:0] HIGH_SUR_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_SUR_MIN  = 16'hDC00;
  localparam logic [15:0] LOW_SUR_MAX  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;
  localparam logic [20:0] ONE_BYTE_MAX = 21'h00007F;
  localparam logic [20:0] TWO_BYTE_MAX = 21'h0007FF;
  localparam logic [20:0] BMP_MAX      = 21'h00FFFF;
  localparam logic [7:0]  CTRL_LIMIT   = 8'h20;
  localparam logic [7:0]  CH_QUOTE     = 8'h22;
  localparam logic [7:0]  CH_BSLASH    = 8'h5C;
  localparam logic [7:0]  CH_U         = 8'h75;

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c inside {[8'h30:8'h39]}) begin
      v = {1'b0, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      v = {1'b0, c[3:0] + 4'd9};
    end
    return v;
  endfunction

  // bit 8 set means not a short escape
  function automatic logic [8:0] esc_byte(input logic [7:0] c);
    logic [8:0] v;
    case (c)
      8'h22:   v = 9'h022;
      8'h5C:   v = 9'h05C;
      8'h2F:   v = 9'h02F;
      8'h62:   v = 9'h008;
      8'h66:   v = 9'h00C;
      8'h6E:   v = 9'h00A;
      8'h72:   v = 9'h00D;
      8'h74:   v = 9'h009;
      default: v = 9'h100;
    endcase
    return v;
  endfunction

  function automatic res_t utf8_enc(input logic [20:0] cp);
    res_t r;
    r.cnt    = 3'd0;
    r.bytes  = '0;
    r.status = ST_BYTE;
    if (cp <= ONE_BYTE_MAX) begin
      r.cnt      = 3'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp <= TWO_BYTE_MAX) begin
      r.cnt      = 3'd2;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= BMP_MAX) begin
      r.cnt      = 3'd3;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      r.cnt      = 3'd4;
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

// File: rtl/jsu_decode.sv
module jsu_decode
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic       opcode,
  input  logic [7:0] text_byte,
  output res_t       res
);

  mode_t       mode_r, mode_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [9:0]  hh_r, hh_nxt;
  logic        clr;

  logic [4:0]  dig;
  logic [8:0]  esc;
  logic [15:0] u;
  logic [20:0] cp_pair;
  logic        is_high, is_low;

  assign dig     = hex_val(text_byte);
  assign esc     = esc_byte(text_byte);
  assign u       = {acc_r, dig[3:0]};
  assign is_high = (u >= HIGH_SUR_MIN) && (u <= HIGH_SUR_MAX);
  assign is_low  = (u >= LOW_SUR_MIN) && (u <= LOW_SUR_MAX);
  assign cp_pair = {1'b0, hh_r, u[9:0]} + SUPP_BASE;

  // next state
  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    hh_nxt   = hh_r;
    clr      = 1'b0;
    if (opcode) begin
      clr = 1'b1;
    end else begin
      case (mode_r)
        MODE_ESC: begin
          if (text_byte == CH_U) begin
            mode_nxt = MODE_HEX1;
            cnt_nxt  = 2'd0;
            acc_nxt  = '0;
          end else if (!esc[8]) begin
            mode_nxt = MODE_PLAIN;
          end else begin
            clr = 1'b1;
          end
        end
        MODE_SUR_BS: begin
          if (text_byte == CH_BSLASH) begin
            mode_nxt = MODE_SUR_U;
          end else begin
            clr = 1'b1;
          end
        end
        MODE_SUR_U: begin
          if (text_byte == CH_U) begin
            mode_nxt = MODE_HEX2;
            cnt_nxt  = 2'd0;
            acc_nxt  = '0;
          end else begin
            clr = 1'b1;
          end
        end
        MODE_HEX1, MODE_HEX2: begin
          if (dig[4]) begin
            clr = 1'b1;
          end else if (cnt_r != 2'd3) begin
            acc_nxt = u[11:0];
            cnt_nxt = cnt_r + 2'd1;
          end else if (mode_r == MODE_HEX1) begin
            cnt_nxt = 2'd0;
            acc_nxt = '0;
            if (is_high) begin
              hh_nxt   = u[9:0];
              mode_nxt = MODE_SUR_BS;
            end else begin
              mode_nxt = MODE_PLAIN;
            end
          end else begin
            clr = 1'b1;
          end
        end
        default: begin
          mode_nxt = MODE_PLAIN;
          if (text_byte == CH_QUOTE) begin
            clr = 1'b1;
          end else if (text_byte == CH_BSLASH) begin
            mode_nxt = MODE_ESC;
          end else if (text_byte < CTRL_LIMIT) begin
            clr = 1'b1;
          end
        end
      endcase
    end
    if (clr) begin
      mode_nxt = MODE_PLAIN;
      cnt_nxt  = 2'd0;
      acc_nxt  = '0;
      hh_nxt   = '0;
    end
  end

  // results of this byte
  always_comb begin
    res.cnt    = 3'd0;
    res.bytes  = '0;
    res.status = ST_BYTE;
    if (opcode) begin
      res.cnt = 3'd1;
      case (mode_r)
        MODE_ESC:                res.status = ST_ESCAPE;
        MODE_HEX1, MODE_HEX2:    res.status = ST_HEX;
        MODE_SUR_BS, MODE_SUR_U: res.status = ST_SURR;
        default:                 res.status = ST_NOQUOTE;
      endcase
    end else begin
      case (mode_r)
        MODE_ESC: begin
          if (text_byte != CH_U) begin
            res.cnt = 3'd1;
            if (!esc[8]) begin
              res.bytes[0] = esc[7:0];
            end else begin
              res.status = ST_ESCAPE;
            end
          end
        end
        MODE_SUR_BS: begin
          if (text_byte != CH_BSLASH) begin
            res.cnt    = 3'd1;
            res.status = ST_SURR;
          end
        end
        MODE_SUR_U: begin
          if (text_byte != CH_U) begin
            res.cnt    = 3'd1;
            res.status = ST_SURR;
          end
        end
        MODE_HEX1, MODE_HEX2: begin
          if (dig[4]) begin
            res.cnt    = 3'd1;
            res.status = ST_HEX;
          end else if (cnt_r == 2'd3) begin
            if (mode_r == MODE_HEX1) begin
              if (!is_high) begin
                res = utf8_enc({5'd0, u});
              end
            end else if (is_low) begin
              res = utf8_enc(cp_pair);
            end else begin
              res.cnt    = 3'd1;
              res.status = ST_SURR;
            end
          end
        end
        default: begin
          if (text_byte == CH_QUOTE) begin
            res.cnt    = 3'd1;
            res.status = ST_OK;
          end else if (text_byte == CH_BSLASH) begin
            res.cnt = 3'd0;
          end else if (text_byte < CTRL_LIMIT) begin
            res.cnt    = 3'd1;
            res.status = ST_CTRL;
          end else begin
            res.cnt      = 3'd1;
            res.bytes[0] = text_byte;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      cnt_r  <= 2'd0;
      acc_r  <= '0;
      hh_r   <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      acc_r  <= acc_nxt;
      hh_r   <= hh_nxt;
    end
  end

endmodule

// File: rtl/jsu_outbuf.sv
`include "json_string_unescape_utf8_defines.svh"

module jsu_outbuf
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  res_t       res,
  output logic       ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [2:0] out_status,
  output logic       out_last
);

  logic [2:0]      rem_r, rem_nxt;
  logic [3:0][7:0] bytes_r, bytes_nxt;
  status_t         status_r, status_nxt;
  logic            take;

  assign out_valid  = (rem_r != 3'd0);
  assign take       = out_valid && !out_stall;
  assign ready      = (rem_r == 3'd0) || ((rem_r == 3'd1) && !out_stall);
  assign out_byte   = bytes_r[0];
  assign out_status = status_r;
  assign out_last   = (rem_r == 3'd1);

  always_comb begin
    rem_nxt    = rem_r;
    bytes_nxt  = bytes_r;
    status_nxt = status_r;
    if (load) begin
      rem_nxt    = res.cnt;
      bytes_nxt  = res.bytes;
      status_nxt = res.status;
    end else if (take) begin
      rem_nxt   = rem_r - 3'd1;
      bytes_nxt = {8'h00, bytes_r[3:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 3'd0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r  <= bytes_nxt;
    status_r <= status_nxt;
  end

  `JSU_ASSERT_IMP(a_rem_range, 1'b1, rem_r <= 3'd4, "pending result count out of range")
  `JSU_ASSERT_IMP(a_load_drained, load, (rem_r == 3'd0) || (take && rem_r == 3'd1), "transaction overwrites pending results")
  `JSU_ASSERT_IMP(a_status_last, out_valid && (status_r != ST_BYTE), out_last, "end status not on the final result")
  `JSU_ASSERT_NEXT(a_drain_goes_on, take && (rem_r > 3'd1), out_valid, "results lost while draining")

endmodule

// File: rtl/json_string_unescape_utf8.sv
// the first result of an accepted byte is registered and offered in the cycle after acceptance
// throughput: one input byte per cycle while each byte gives at most one result and the output is not stalled
// a byte giving n results offers them on the output one result per cycle while the output is not stalled;
// input is stalled while more than one result is still pending, or while one is pending and the output is stalled
// synchronous active-low reset: plain text mode, counters cleared, no results pending
module json_string_unescape_utf8
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_opcode,
  input  logic [7:0] in_text_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_out_byte,
  output logic [2:0] out_status,
  output logic       out_last
);

  res_t res;
  logic ready;
  logic fire;

  assign in_stall = !ready;
  assign fire     = in_valid && ready;

  jsu_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .opcode    (in_opcode),
    .text_byte (in_text_byte),
    .res       (res)
  );

  jsu_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .res        (res),
    .ready      (ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_out_byte),
    .out_status (out_status),
    .out_last   (out_last)
  );

endmodule
